// File: sv/assert_macros.svh
// Assertion helpers used by the RTL of the sprite line block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every rising edge outside reset.
`define SPLG_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The expression must never hold at a rising edge outside reset.
`define SPLG_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: sv/splg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package splg_pkg;

  // Default graphics ROM size in bytes.
  localparam int ROM_DEPTH_DEF = 32768;

  // Output queue depth; the column walk needs room for four beats to issue.
  localparam int FIFO_DEPTH = 8;

  // Columns walked per sprite row.
  localparam int COLS = 16;

  // Operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // Transparent pen codes.
  localparam logic [3:0] NIB_CLEAR = 4'h0;
  localparam logic [3:0] NIB_SOLID = 4'hf;

  typedef logic [14:0] rom_addr_t;

  typedef struct packed {
    logic       op;
    logic [14:0] rom_address;
    logic [7:0] rom_data;
    logic [7:0] sprite_control;
    logic [7:0] sprite_y_raw;
    logic [7:0] sprite_tile;
    logic [7:0] sprite_x;
    logic [8:0] scan_line;
  } in_beat_t;

  typedef struct packed {
    logic [8:0] pixel_x;
    logic [4:0] pixel_color;
    logic       last;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  // A pen is drawn unless it is one of the two transparent codes.
  function automatic logic opaque(input logic [3:0] nib);
    return (nib != NIB_CLEAR) && (nib != NIB_SOLID);
  endfunction

endpackage

`default_nettype wire

// File: sv/splg_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module splg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// File: sv/sprite_line_pixel_generator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Channel   Direction  Handshake            Beat
// in        input      in_valid / in_stall  one load or one draw entry
// out       output     out_valid/out_stall  one opaque pixel, last on the final one
//
// A load, or a draw whose scanline misses the sprite, leaves the block idle.
// A draw that hits reads one ROM column per cycle while the queue has room (main
// and partner byte on the two read ports), then returns to accept the next beat.
// Pixels pass through an 8-beat queue; when out is stalled the walk pauses
// until four places are free. rst is synchronous; the ROM is not cleared.

module sprite_line_pixel_generator_unit #(
  parameter int ROM_DEPTH = splg_pkg::ROM_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire splg_pkg::in_beat_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output splg_pkg::out_beat_t       out_data
);

  import splg_pkg::*;

  localparam int AW = $clog2(ROM_DEPTH);
  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int KW = $clog2(COLS);

  state_t state, state_next;

  // Sprite parameters latched on every accepted draw.
  logic       hr, hs, a7, a8;
  logic [5:0] bank;
  logic [3:0] row;
  logic [7:0] xpos;

  // Column walk and the read in flight.
  logic [KW:0]   col;
  logic          issue;
  logic          rd_valid;
  logic [KW-1:0] rd_col;

  // Held pixel: only known to be the last once the walk ends.
  logic      pend_valid, pend_valid_next;
  out_beat_t pend, pend_next;

  // Output queue.
  out_beat_t     fifo [FIFO_DEPTH];
  logic [PW-1:0] head, tail;
  logic [CW-1:0] count;
  logic          pop;
  logic [1:0]    push_n;
  out_beat_t     push0, push1;

  // Decode of the incoming beat.
  logic       accept, load_we, hit;
  logic [9:0] diff;
  logic       in_vr, in_hr, in_hs;
  logic [4:0] vsize;
  logic [7:0] ypos;

  // ROM ports.
  logic [KW-1:0] ctr;
  rom_addr_t     raddr_m, raddr_p;
  logic [7:0]    rdata_m, rdata_p;

  // Data stage.
  logic          odd;
  logic [3:0]    nib_m, nib_p;
  logic          main_ok, part_ok;
  logic [8:0]    xm, xp;

  // Line test and address modifiers of the incoming entry.
  always_comb begin
    in_vr  = in_data.sprite_control[7];
    in_hr  = in_data.sprite_control[6];
    in_hs  = in_data.sprite_control[5];
    vsize  = in_data.sprite_control[4:0];
    ypos   = ~in_data.sprite_y_raw;
    diff   = {1'b0, in_data.scan_line} - {2'b00, ypos};
    hit    = !diff[9] && (diff[8:0] <= {4'b0000, vsize});
    accept = in_valid && !in_stall;
    load_we = accept && (in_data.op == OP_LOAD);
  end

  // Latch the sprite entry when a draw is accepted.
  always_ff @(posedge clk) begin
    if (accept && in_data.op == OP_DRAW) begin
      hr   <= in_hr;
      hs   <= in_hs;
      a8   <= in_data.sprite_tile[1] ^ (in_hs & ~in_hr);
      a7   <= ~(~((in_vr ^ diff[4]) & vsize[4]) & in_data.sprite_tile[0]);
      bank <= in_data.sprite_tile[7:2];
      row  <= diff[3:0] ^ {4{in_vr}};
      xpos <= in_data.sprite_x;
    end
  end

  // Column address; the partner half differs in A8.
  always_comb begin
    ctr     = hr ? ~col[KW-1:0] : col[KW-1:0];
    raddr_m = {bank, a8, a7, row, ctr[KW-1:1]};
    raddr_p = {bank, ~a8, a7, row, ctr[KW-1:1]};
  end

  splg_ram #(
    .WIDTH (8),
    .DEPTH (ROM_DEPTH)
  ) u_rom (
    .clk     (clk),
    .we      (load_we),
    .waddr   (AW'(in_data.rom_address)),
    .wdata   (in_data.rom_data),
    .raddr_a (AW'(raddr_m)),
    .rdata_a (rdata_m),
    .raddr_b (AW'(raddr_p)),
    .rdata_b (rdata_p)
  );

  // Pixel decode of the column returned by the ROM.
  always_comb begin
    odd     = hr ? ~rd_col[0] : rd_col[0];
    nib_m   = odd ? rdata_m[3:0] : rdata_m[7:4];
    nib_p   = odd ? rdata_p[3:0] : rdata_p[7:4];
    main_ok = opaque(nib_m);
    part_ok = hs && opaque(nib_p);
    xm      = {1'b0, xpos} + {{(9-KW){1'b0}}, rd_col};
    xp      = xm + 9'(COLS);
  end

  // Emit every pixel but the newest, which waits in the held slot until the flush marks it last.
  always_comb begin
    push_n          = 2'd0;
    push0           = pend;
    push1           = pend;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    if (rd_valid) begin
      if (main_ok) begin
        if (pend_valid_next) begin
          push0  = pend_next;
          push_n = 2'd1;
        end
        pend_next       = '{pixel_x: xm, pixel_color: {1'b1, nib_m}, last: 1'b0};
        pend_valid_next = 1'b1;
      end
      if (part_ok) begin
        if (pend_valid_next) begin
          if (push_n == 2'd0) begin
            push0 = pend_next;
          end else begin
            push1 = pend_next;
          end
          push_n = push_n + 2'd1;
        end
        pend_next       = '{pixel_x: xp, pixel_color: {1'b1, nib_p}, last: 1'b0};
        pend_valid_next = 1'b1;
      end
    end else if (state == ST_FLUSH && pend_valid && count < CW'(FIFO_DEPTH)) begin
      push0           = pend;
      push0.last      = 1'b1;
      push_n          = 2'd1;
      pend_valid_next = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_data.op == OP_DRAW && hit) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (col[KW] && !rd_valid) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid || count < CW'(FIFO_DEPTH)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    unique case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_WALK:  issue = !col[KW] && (count <= CW'(FIFO_DEPTH - 4));
      ST_FLUSH: in_stall = 1'b1;
      default:  in_stall = 1'b1;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      col        <= '0;
      rd_valid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      rd_valid   <= issue;
      pend_valid <= pend_valid_next;
      if (state == ST_IDLE) begin
        col <= '0;
      end else if (issue) begin
        col <= col + (KW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_col <= col[KW-1:0];
    pend   <= pend_next;
  end

  // Output queue: up to two writes and one read per cycle.
  always_comb begin
    out_valid = (count != '0);
    out_data  = fifo[head];
    pop       = out_valid && !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + PW'(pop);
      tail  <= tail + PW'(push_n);
      count <= count + CW'(push_n) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo[tail] <= push0;
    end
    if (push_n == 2'd2) begin
      fifo[tail + PW'(1)] <= push1;
    end
  end

  `SPLG_NEVER(a_fifo_overflow, count > CW'(FIFO_DEPTH), "output queue overflow")
  `SPLG_NEVER(a_read_outside_walk, rd_valid && state != ST_WALK, "ROM read outside the walk")
  `SPLG_NEVER(a_held_pixel_idle, state == ST_IDLE && pend_valid, "held pixel left behind")

endmodule

`default_nettype wire
